// ----- design/cwac_pkg.sv -----
// shared types, constants and lookup functions of the accent classifier
// used by cwac_ctrl, cwac_dp and the top level
`timescale 1ns / 1ps
package cwac_pkg;

  localparam int W          = 4;               // half window
  localparam int FULLW      = 2 * W + 1;
  localparam int NTREES     = 5;
  localparam int NODES      = 256;
  localparam int IDX_W      = 8;
  localparam int TADDR_W    = 11;
  localparam int TDEPTH     = NTREES * NODES;
  localparam int STEP_LIMIT = 200;
  localparam int STEP_W     = 8;
  localparam int FILL_W     = 4;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 9;

  localparam logic [1:0] REQ_TEXT  = 2'd0;
  localparam logic [1:0] REQ_NODE  = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PAD   = 8'h5F;
  localparam logic [7:0] CH_OTHER = 8'h2A;
  localparam logic [7:0] CH_DIGIT = 8'h30;

  localparam logic [2:0] SLOT_NONE = 3'd7;

  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] offset;
    logic [8:0] left;
    logic [8:0] right;
    logic [1:0] label;
    logic       leaf;
  } node_t;

  typedef struct packed {
    logic latch;
    logic shift_text;
    logic shift_pad;
    logic pad_space;
    logic node_write;
    logic win_reset;
    logic walk_start;
    logic walk_step;
    logic emit;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       fill_full;
    logic       fill_zero;
    logic       center_vowel;
    logic       root_bad;
    logic       walk_end;
    logic       out_free;
  } stat_t;

  function automatic logic [7:0] norm_char(input logic [7:0] c);
    if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13)) return CH_SPACE;
    if (c >= 8'h30 && c <= 8'h39) return CH_DIGIT;
    if (c >= 8'h41 && c <= 8'h5A) return c + 8'd32;
    if (c >= 8'h61 && c <= 8'h7A) return c;
    if (c >= 8'd33 && c <= 8'd126) return CH_PAD;
    return CH_OTHER;
  endfunction

  function automatic logic [2:0] vowel_slot(input logic [7:0] c);
    case (c)
      8'h61: return 3'd0;
      8'h65: return 3'd1;
      8'h69: return 3'd2;
      8'h6F: return 3'd3;
      8'h75: return 3'd4;
      default: return SLOT_NONE;
    endcase
  endfunction

  function automatic logic [2:0] accent_count(input logic [2:0] slot);
    case (slot)
      3'd3, 3'd4: return 3'd4;
      default: return 3'd2;
    endcase
  endfunction

  function automatic logic [8:0] code_point(input logic [2:0] slot, input logic [1:0] lab,
                                            input logic upper);
    logic [8:0] cp;
    cp = 9'd0;
    case ({slot, lab})
      {3'd0, 2'd0}: cp = 9'h61;
      {3'd0, 2'd1}: cp = 9'hE1;
      {3'd1, 2'd0}: cp = 9'h65;
      {3'd1, 2'd1}: cp = 9'hE9;
      {3'd2, 2'd0}: cp = 9'h69;
      {3'd2, 2'd1}: cp = 9'hED;
      {3'd3, 2'd0}: cp = 9'h6F;
      {3'd3, 2'd1}: cp = 9'hF3;
      {3'd3, 2'd2}: cp = 9'hF6;
      {3'd3, 2'd3}: cp = 9'h151;
      {3'd4, 2'd0}: cp = 9'h75;
      {3'd4, 2'd1}: cp = 9'hFA;
      {3'd4, 2'd2}: cp = 9'hFC;
      {3'd4, 2'd3}: cp = 9'h171;
      default: cp = 9'd0;
    endcase
    // upper case sits 0x20 below, double acute one below
    if (upper && cp != 9'd0) begin
      if (lab == 2'd3) cp = cp - 9'd1;
      else cp = cp - 9'h20;
    end
    return cp;
  endfunction

endpackage

// ----- design/char_window_tree_accent_classifier_unit.sv -----
// top level of the sliding-window decision-tree accent classifier
// depends on cwac_pkg, cwac_ctrl, cwac_dp
`timescale 1ns / 1ps
// Text bytes enter one transfer at a time and are normalized into a nine
// character window; each character that reaches the center leaves as one
// result transfer four text bytes later. A text byte that releases no
// character is latched and dispatched; one that releases a non-vowel, or a
// vowel whose tree is empty, also passes the center and emit states. A
// center vowel walks its tree in the node memory, one node per step; a step
// is one registered memory read plus one compare, with at most 202 reads
// when the walk runs into its step limit. Node writes are made in dispatch.
// An end-of-text flush shifts in one pad per shift state and runs the
// center, walk and emit states of each pending character, the final one
// marked by out_tlast, then restores the padded window. A stalled result
// side holds the controller in its emit state. The output register lets the
// next input be taken while a result waits.
module char_window_tree_accent_classifier_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cwac_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [cwac_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // tdata: text_byte, tree_sel, node_index, node_char, node_offset,
  //        node_left, node_right, node_label, zero fill
  input  logic [55:0]                 in_tdata,
  // tuser: req_type
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // tdata: orig_byte, accent_label, code_point, zero fill
  output logic [23:0]                 out_tdata,
  // tuser: is_vowel
  output logic                        out_tuser,
  output logic                        out_tlast
);

  cwac_pkg::cmd_t  cmd;
  cwac_pkg::stat_t stat;

  cwac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cwac_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

  // a non-vowel passes its raw byte through with plain label
  a_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[9:8] == 2'd0 &&
                                    out_tdata[18:10] == {1'b0, out_tdata[7:0]}))
    else $error("non-vowel result altered");

  // vowels a, e, i have only the acute accent
  a_label: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && out_tdata[9]) |->
      (out_tdata[7:0] == 8'h6F || out_tdata[7:0] == 8'h75 ||
       out_tdata[7:0] == 8'h4F || out_tdata[7:0] == 8'h55))
    else $error("accent beyond vowel range");

  // no new emit while input is being taken
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmd.emit)
    else $error("emit while idle");

endmodule

// ----- design/cwac_ctrl.sv -----
// controller of the accent classifier: sequences shifts, tree walks and emits
// depends on cwac_pkg
`timescale 1ns / 1ps
module cwac_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  cwac_pkg::stat_t stat,
  output cwac_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DISP   = 7'b0000010,
    S_FSHIFT = 7'b0000100,
    S_CENTER = 7'b0001000,
    S_READ   = 7'b0010000,
    S_EVAL   = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic       flush_r, flush_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    flush_nxt = flush_r;
    cmd       = '0;
    cmd.pad_space = (k_r == 2'd0);
    cmd.emit_last = flush_r && (k_r == 2'(cwac_pkg::W - 1));
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        flush_nxt = 1'b0;
        state_nxt = S_IDLE;
        case (stat.req)
          cwac_pkg::REQ_TEXT: begin
            cmd.shift_text = 1'b1;
            if (stat.fill_full) state_nxt = S_CENTER;
          end
          cwac_pkg::REQ_NODE: cmd.node_write = 1'b1;
          cwac_pkg::REQ_FLUSH: begin
            if (stat.fill_zero) begin
              cmd.win_reset = 1'b1;
            end else begin
              k_nxt     = 2'd0;
              flush_nxt = 1'b1;
              state_nxt = S_FSHIFT;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_FSHIFT: begin
        cmd.shift_pad = 1'b1;
        if (stat.fill_full) state_nxt = S_CENTER;
        else k_nxt = k_r + 2'd1;
      end
      S_CENTER: begin
        if (!stat.center_vowel) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt = stat.root_bad ? S_EMIT : S_READ;
        end
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        cmd.walk_step = 1'b1;
        state_nxt = stat.walk_end ? S_EMIT : S_READ;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (!flush_r) begin
            state_nxt = S_IDLE;
          end else if (k_r == 2'(cwac_pkg::W - 1)) begin
            cmd.win_reset = 1'b1;
            flush_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 2'd1;
            state_nxt = S_FSHIFT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= 2'd0;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule

// ----- design/cwac_dp.sv -----
// datapath of the accent classifier: window, node memory, walk unit, output register
// depends on cwac_pkg
`timescale 1ns / 1ps
module cwac_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cwac_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [cwac_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic [1:0]                  in_tuser,
  input  logic [55:0]                 in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,
  output logic                        out_tuser,
  output logic                        out_tlast,
  input  cwac_pkg::cmd_t              cmd,
  output cwac_pkg::stat_t             stat
);

  logic [8:0]  count_r [0:cwac_pkg::NTREES-1];
  logic [7:0]  win_r   [0:cwac_pkg::FULLW-1];
  logic [7:0]  raw_r   [0:cwac_pkg::W];
  logic [cwac_pkg::FILL_W-1:0] fill_r;

  logic [1:0]  req_r;
  logic [55:0] dat_r;

  cwac_pkg::node_t node_mem [0:cwac_pkg::TDEPTH-1];
  cwac_pkg::node_t rdata_r;
  logic [cwac_pkg::TADDR_W-1:0] addr_r;
  logic [cwac_pkg::STEP_W-1:0]  steps_r;
  logic        first_r;
  logic [1:0]  label_r;

  logic        out_valid_r, out_vowel_r, out_last_r;
  logic [7:0]  out_orig_r;
  logic [1:0]  out_label_r;
  logic [8:0]  out_cp_r;

  // input fields of the latched transfer
  logic [7:0] f_text, f_idx;
  logic [2:0] f_sel;
  cwac_pkg::node_t wnode;
  assign f_text       = dat_r[7:0];
  assign f_sel        = dat_r[10:8];
  assign f_idx        = dat_r[18:11];
  assign wnode.ch     = dat_r[26:19];
  assign wnode.offset = dat_r[30:27];
  assign wnode.left   = dat_r[39:31];
  assign wnode.right  = dat_r[48:40];
  assign wnode.label  = dat_r[50:49];
  assign wnode.leaf   = (dat_r[39:31] == 9'h1FF) && (dat_r[48:40] == 9'h1FF);

  // walk evaluation
  logic [2:0]        slot;
  logic [8:0]        count;
  logic signed [4:0] pos;
  logic              match;
  logic [8:0]        nxt_idx;
  logic              nxt_bad, leaf_hit, limit_hit;
  logic [1:0]        leaf_lab;

  assign slot  = cwac_pkg::vowel_slot(win_r[cwac_pkg::W]);
  assign count = (slot == cwac_pkg::SLOT_NONE) ? 9'd0 :
                 (count_r[slot] > 9'(cwac_pkg::NODES)) ? 9'(cwac_pkg::NODES) : count_r[slot];
  assign pos   = 5'(cwac_pkg::W) + {rdata_r.offset[3], rdata_r.offset};
  assign match = (pos >= 0) && (pos < 5'(cwac_pkg::FULLW)) &&
                 (win_r[pos[3:0]] == rdata_r.ch);
  assign nxt_idx   = match ? rdata_r.right : rdata_r.left;
  assign nxt_bad   = nxt_idx[8] || (nxt_idx >= count);
  assign leaf_hit  = !first_r && rdata_r.leaf;
  assign limit_hit = (steps_r == 8'(cwac_pkg::STEP_LIMIT + 1));
  assign leaf_lab  = ({1'b0, rdata_r.label} < cwac_pkg::accent_count(slot)) ? rdata_r.label : 2'd0;

  assign stat.req          = req_r;
  assign stat.fill_full    = (fill_r == 4'(cwac_pkg::W));
  assign stat.fill_zero    = (fill_r == '0);
  assign stat.center_vowel = (slot != cwac_pkg::SLOT_NONE);
  assign stat.root_bad     = (count == 9'd0);
  assign stat.walk_end     = leaf_hit || limit_hit || nxt_bad;
  assign stat.out_free     = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cwac_pkg::NTREES; i++) count_r[i] <= 9'd0;
    end else if (cfg_we && cfg_addr < 3'(cwac_pkg::NTREES)) begin
      count_r[cfg_addr] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_tuser;
      dat_r <= in_tdata;
    end
  end

  // window and fill counter
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.win_reset) begin
      for (int i = 0; i < cwac_pkg::FULLW - 1; i++) win_r[i] <= cwac_pkg::CH_PAD;
      win_r[cwac_pkg::FULLW-1] <= cwac_pkg::CH_SPACE;
      fill_r <= '0;
    end else if (cmd.shift_text || cmd.shift_pad) begin
      for (int i = 0; i < cwac_pkg::FULLW - 1; i++) win_r[i] <= win_r[i+1];
      if (cmd.shift_text) win_r[cwac_pkg::FULLW-1] <= cwac_pkg::norm_char(f_text);
      else win_r[cwac_pkg::FULLW-1] <= cmd.pad_space ? cwac_pkg::CH_SPACE : cwac_pkg::CH_PAD;
      if (fill_r != 4'(cwac_pkg::W)) fill_r <= fill_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_text || cmd.shift_pad) begin
      for (int i = 0; i < cwac_pkg::W; i++) raw_r[i] <= raw_r[i+1];
      raw_r[cwac_pkg::W] <= cmd.shift_text ? f_text : 8'd0;
    end
  end

  // node memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.node_write && f_sel < 3'(cwac_pkg::NTREES))
      node_mem[{f_sel, f_idx}] <= wnode;
    rdata_r <= node_mem[addr_r];
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      addr_r  <= {slot, 8'd0};
      steps_r <= '0;
      first_r <= 1'b1;
      label_r <= 2'd0;
    end else if (cmd.walk_step) begin
      if (leaf_hit) label_r <= leaf_lab;
      addr_r  <= {slot, nxt_idx[7:0]};
      steps_r <= steps_r + 8'd1;
      first_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_orig_r  <= raw_r[0];
      out_last_r  <= cmd.emit_last;
      out_vowel_r <= stat.center_vowel;
      out_label_r <= stat.center_vowel ? label_r : 2'd0;
      out_cp_r    <= stat.center_vowel ?
                     cwac_pkg::code_point(slot, label_r, raw_r[0] >= 8'h41 && raw_r[0] <= 8'h5A) :
                     {1'b0, raw_r[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cp_r, out_label_r, out_orig_r};
  assign out_tuser  = out_vowel_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- test/tb_char_window_tree_accent_classifier_unit.sv -----
// self-checking bench for the window tree accent classifier: directed table then random traffic
// depends on cwac_pkg and char_window_tree_accent_classifier_unit
`timescale 1ns / 1ps
module tb_char_window_tree_accent_classifier_unit;

  // request code outside the defined set
  localparam logic [1:0] REQ_BAD = 2'd3;
  // node slots per tree that the bench loads and points at
  localparam int TREE_N = 12;

  // one input transfer, unpacked
  typedef struct {
    logic [1:0] req;
    logic [7:0] text_byte;
    logic [2:0] tree_sel;
    logic [7:0] node_index;
    logic [7:0] node_char;
    logic [3:0] node_offset;
    logic [8:0] node_left;
    logic [8:0] node_right;
    logic [1:0] node_label;
  } req_t;

  // one result transfer
  typedef struct {
    logic [7:0] orig;
    logic       vowel;
    logic [1:0] label;
    logic [8:0] cp;
    logic       last;
  } res_t;

  // one row of the directed table: a register write or an input transfer
  typedef struct {
    bit         is_cfg;
    logic [2:0] addr;
    logic [8:0] cval;
    req_t       rq;
    bit         chk;
    res_t       want;
  } row_t;

  typedef struct {
    logic [7:0] ch;
    int         offset;
    int         left;
    int         right;
    logic [1:0] label;
    bit         leaf;
  } tnode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [8:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  char_window_tree_accent_classifier_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // accent code points per vowel, lower and upper case
  localparam int ACC_N[5] = '{2, 2, 2, 4, 4};
  localparam int CP_LO[5][4] = '{'{'h61, 'hE1, 0, 0}, '{'h65, 'hE9, 0, 0},
                                 '{'h69, 'hED, 0, 0}, '{'h6F, 'hF3, 'hF6, 'h151},
                                 '{'h75, 'hFA, 'hFC, 'h171}};
  localparam int CP_UP[5][4] = '{'{'h41, 'hC1, 0, 0}, '{'h45, 'hC9, 0, 0},
                                 '{'h49, 'hCD, 0, 0}, '{'h4F, 'hD3, 'hD6, 'h150},
                                 '{'h55, 'hDA, 'hDC, 'h170}};

  // predictor state
  tnode_t     trees [5][256];
  int         tree_len [5];
  logic [7:0] win [9];
  logic [7:0] raw_hist [5];
  int         pending;

  res_t       accent_q [$];
  int         errors = 0;
  int         sent = 0;
  int         received = 0;
  int         label_hits [4] = '{0, 0, 0, 0};
  int         burst_left = 0;

  function automatic logic [7:0] fold_char(logic [7:0] c);
    if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13)) return 8'h20;
    if (c >= "0" && c <= "9") return "0";
    if (c >= "A" && c <= "Z") return c + 8'd32;
    if (c >= "a" && c <= "z") return c;
    if (c >= 8'd33 && c <= 8'd126) return "_";
    return "*";
  endfunction

  function automatic int vowel_of(logic [7:0] c);
    case (c)
      "a": return 0;
      "e": return 1;
      "i": return 2;
      "o": return 3;
      "u": return 4;
      default: return -1;
    endcase
  endfunction

  task automatic clear_window();
    for (int k = 0; k < 9; k++) win[k] = "_";
    win[8] = 8'h20;
    for (int k = 0; k < 5; k++) raw_hist[k] = 8'h00;
    pending = 0;
  endtask

  task automatic push_char(logic [7:0] nc, logic [7:0] raw);
    for (int k = 0; k < 8; k++) win[k] = win[k+1];
    win[8] = nc;
    for (int k = 0; k < 4; k++) raw_hist[k] = raw_hist[k+1];
    raw_hist[4] = raw;
  endtask

  // walk one vowel tree from the root; any failure gives the plain label
  function automatic int tree_label(int v);
    int cnt, idx, pos, nxt;
    cnt = tree_len[v] > 256 ? 256 : tree_len[v];
    idx = 0;
    for (int step = 0; step <= 200; step++) begin
      if (idx >= cnt) return 0;
      pos = 4 + trees[v][idx].offset;
      if (pos >= 0 && pos < 9 && win[pos] == trees[v][idx].ch) nxt = trees[v][idx].right;
      else nxt = trees[v][idx].left;
      if (nxt < 0 || nxt >= cnt) return 0;
      if (trees[v][nxt].leaf)
        return trees[v][nxt].label < ACC_N[v] ? int'(trees[v][nxt].label) : 0;
      idx = nxt;
    end
    return 0;
  endfunction

  task automatic emit_center(bit last);
    res_t r;
    int v, lab;
    v = vowel_of(win[4]);
    r.orig = raw_hist[0];
    r.last = last;
    if (v < 0) begin
      r.vowel = 1'b0;
      r.label = 2'd0;
      r.cp = {1'b0, raw_hist[0]};
    end else begin
      lab = tree_label(v);
      r.vowel = 1'b1;
      r.label = lab[1:0];
      r.cp = (raw_hist[0] >= "A" && raw_hist[0] <= "Z") ? 9'(CP_UP[v][lab])
                                                         : 9'(CP_LO[v][lab]);
    end
    accent_q = {accent_q, r};
  endtask

  // advance the predictor by one accepted transfer
  task automatic predict_accent(req_t r);
    int remain;
    case (r.req)
      cwac_pkg::REQ_TEXT: begin
        push_char(fold_char(r.text_byte), r.text_byte);
        pending++;
        if (pending > 4) begin
          emit_center(1'b0);
          pending--;
        end
      end
      cwac_pkg::REQ_NODE: begin
        if (r.tree_sel <= 3'd4) begin
          trees[r.tree_sel][r.node_index].ch = r.node_char;
          trees[r.tree_sel][r.node_index].offset = int'($signed(r.node_offset));
          trees[r.tree_sel][r.node_index].left = int'($signed(r.node_left));
          trees[r.tree_sel][r.node_index].right = int'($signed(r.node_right));
          trees[r.tree_sel][r.node_index].label = r.node_label;
          trees[r.tree_sel][r.node_index].leaf = (r.node_left == 9'h1FF) &&
                                                 (r.node_right == 9'h1FF);
        end
      end
      cwac_pkg::REQ_FLUSH: begin
        remain = pending;
        for (int k = 0; k < 4 && remain > 0; k++) begin
          push_char(k == 0 ? 8'h20 : "_", 8'h00);
          pending++;
          if (pending > 4) begin
            remain--;
            emit_center(remain == 0);
            pending--;
          end
        end
        clear_window();
      end
      default: ;
    endcase
  endtask

  function automatic req_t text_req(logic [7:0] b);
    req_t r;
    r = '{default: '0};
    r.req = cwac_pkg::REQ_TEXT;
    r.text_byte = b;
    return r;
  endfunction

  function automatic req_t node_req(int sel, int idx, logic [7:0] ch, int off,
                                    int lft, int rgt, int lab);
    req_t r;
    r = '{default: '0};
    r.req = cwac_pkg::REQ_NODE;
    r.tree_sel = sel[2:0];
    r.node_index = idx[7:0];
    r.node_char = ch;
    r.node_offset = off[3:0];
    r.node_left = lft[8:0];
    r.node_right = rgt[8:0];
    r.node_label = lab[1:0];
    return r;
  endfunction

  // send one transfer in bursts with random gaps; valid stays up inside a burst
  task automatic put_item(req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.req;
    in_tdata <= {5'd0, r.node_label, r.node_right, r.node_left, r.node_offset,
                 r.node_char, r.node_index, r.tree_sel, r.text_byte};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sent++;
    predict_accent(r);
  endtask

  // hold off until every expected result is back, then let the block settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (accent_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_count(int addr, int val);
    cfg_we <= 1'b1;
    cfg_addr <= addr[2:0];
    cfg_wdata <= val[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    tree_len[addr] = val;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_text();
    int r;
    string vow, sym;
    vow = "aeiouAEIOU";
    sym = " _0.";
    r = $urandom_range(0, 99);
    if (r < 40) return vow[$urandom_range(0, 9)];
    if (r < 55) return sym[$urandom_range(0, 3)];
    if (r < 80) return "a" + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_node_char();
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0: return 8'h20;
      1: return "_";
      2: return "0";
      3: return "*";
      default: return "a" + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // twelve-node acyclic tree: children always point further down, the tail is a leaf
  task automatic build_tree(int v);
    for (int i = 0; i < TREE_N; i++) begin
      if (i == TREE_N - 1 || (i > 0 && $urandom_range(0, 2) == 0))
        put_item(node_req(v, i, 8'($urandom), $urandom_range(0, 15), -1, -1,
                          $urandom_range(0, 3)));
      else
        put_item(node_req(v, i, pick_node_char(), int'($urandom_range(0, 8)) - 4,
                          $urandom_range(i + 1, TREE_N - 1),
                          $urandom_range(i + 1, TREE_N - 1),
                          $urandom_range(0, 3)));
    end
  endtask

  // result side: stall pattern is redrawn each time stall_cnt wraps
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk) begin
    res_t want;
    if (stall_cnt == 63) stall_mode <= $urandom_range(0, 3);
    stall_cnt <= (stall_cnt + 1) % 64;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (stall_cnt % 8) < 5;
    endcase
    if (rst_n && out_tvalid && out_tready) begin
      received++;
      if (accent_q.size() == 0) begin
        $error("result transfer with nothing expected: tdata %h", out_tdata);
        errors++;
      end else begin
        want = accent_q[0];
        accent_q.delete(0);
        if (out_tdata[7:0] !== want.orig) begin
          $error("orig_byte expected %h got %h", want.orig, out_tdata[7:0]); errors++;
        end
        if (out_tuser !== want.vowel) begin
          $error("is_vowel expected %0d got %0d", want.vowel, out_tuser); errors++;
        end
        if (out_tdata[9:8] !== want.label) begin
          $error("accent_label expected %0d got %0d", want.label, out_tdata[9:8]); errors++;
        end
        if (out_tdata[18:10] !== want.cp) begin
          $error("code_point expected %h got %h", want.cp, out_tdata[18:10]); errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last expected %0d got %0d", want.last, out_tlast); errors++;
        end
        if (want.vowel) label_hits[want.label]++;
      end
    end
  end

  // directed table helpers
  function automatic row_t row_in(req_t r);
    row_t w;
    w = '{default: '0};
    w.rq = r;
    return w;
  endfunction

  function automatic row_t row_chk(req_t r, logic [7:0] o, bit v, int lab, int cp);
    row_t w;
    w = row_in(r);
    w.chk = 1'b1;
    w.want = '{orig: o, vowel: v, label: lab[1:0], cp: cp[8:0], last: 1'b0};
    return w;
  endfunction

  function automatic row_t row_cfg(int addr, int val);
    row_t w;
    w = '{default: '0};
    w.is_cfg = 1'b1;
    w.addr = addr[2:0];
    w.cval = val[8:0];
    return w;
  endfunction

  row_t plan [$];

  initial begin
    req_t rq;
    int n, rr, tsel;
    for (int v = 0; v < 5; v++) begin
      tree_len[v] = 0;
      for (int i = 0; i < 256; i++) trees[v][i] = '{default: 0};
    end
    clear_window();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every node slot that a child can name is loaded as a plain leaf first
    for (int v = 0; v < 5; v++)
      for (int i = 0; i < TREE_N; i++) put_item(node_req(v, i, 8'h00, 0, -1, -1, 0));

    // empty trees: vowels come out plain, other bytes pass through
    plan = {plan, row_in(text_req("A"))};
    plan = {plan, row_in(text_req(8'h00))};
    plan = {plan, row_in(text_req(8'hFF))};
    plan = {plan, row_in(text_req("9"))};
    plan = {plan, row_chk(text_req("z"), "A", 1'b1, 0, 'h41)};
    plan = {plan, row_chk(text_req(8'h20), 8'h00, 1'b0, 0, 'h00)};
    rq = '{default: '0};
    rq.req = cwac_pkg::REQ_FLUSH;
    plan = {plan, row_in(rq)};              // flush with four pending
    plan = {plan, row_in(rq)};              // flush with nothing pending
    rq.req = REQ_BAD;
    plan = {plan, row_in(rq)};              // undefined request
    plan = {plan, row_in(node_req(7, 255, 8'hFF, -8, 255, 255, 3))};  // bad tree select
    // o tree: space just before the center picks double acute, else umlaut
    plan = {plan, row_in(node_req(3, 0, 8'h20, -1, 2, 1, 0))};
    plan = {plan, row_in(node_req(3, 1, 8'h00, 0, -1, -1, 3))};
    plan = {plan, row_in(node_req(3, 2, 8'h00, 0, -1, -1, 2))};
    plan = {plan, row_cfg(3, 3)};
    plan = {plan, row_in(text_req(8'h20))};
    plan = {plan, row_in(text_req("O"))};
    plan = {plan, row_in(text_req("a"))};
    plan = {plan, row_in(text_req("b"))};
    plan = {plan, row_chk(text_req("c"), 8'h20, 1'b0, 0, 'h20)};
    plan = {plan, row_chk(text_req("d"), "O", 1'b1, 3, 'h150)};
    // u tree whose root points at itself: the walk runs out of steps
    plan = {plan, row_in(node_req(4, 0, 8'h00, 0, 0, 0, 1))};
    plan = {plan, row_cfg(4, 1)};
    plan = {plan, row_cfg(0, 256)};
    plan = {plan, row_cfg(1, 511)};
    plan = {plan, row_cfg(2, 0)};
    plan = {plan, row_in(text_req("u"))};
    rq.req = cwac_pkg::REQ_FLUSH;
    plan = {plan, row_in(rq)};

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_count(plan[i].addr, plan[i].cval);
      end else begin
        n = accent_q.size();
        put_item(plan[i].rq);
        // typed expectation replaces the predicted one on these rows
        if (plan[i].chk && accent_q.size() == n + 1)
          accent_q[accent_q.size() - 1] = plan[i].want;
      end
    end

    // random phases: idle, new counts, fresh trees, then mixed traffic
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      for (int v = 0; v < 5; v++) begin
        case (ph)
          0: write_count(v, 40);
          4: write_count(v, (v % 2) ? 511 : 256);
          5: write_count(v, (v == 2) ? 0 : 40);
          default: write_count(v, $urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                             : $urandom_range(1, 40));
        endcase
      end
      tsel = $urandom_range(0, 4);
      for (int v = 0; v < 5; v++) if (ph == 0 || v == tsel) build_tree(v);
      for (int i = 0; i < 26; i++) begin
        rr = $urandom_range(0, 99);
        rq = text_req(pick_text());
        if (rr >= 80 && rr < 88) rq.req = cwac_pkg::REQ_FLUSH;
        else if (rr >= 88 && rr < 96)
          rq = node_req($urandom_range(0, 4), $urandom_range(0, TREE_N - 1),
                        pick_node_char(), $urandom_range(0, 15),
                        int'($urandom_range(0, TREE_N)) - 1,
                        int'($urandom_range(0, TREE_N)) - 1, $urandom_range(0, 3));
        else if (rr >= 96) begin
          // raw noise over the field bits, undefined requests included
          rq.req = 2'($urandom);
          if (rq.req == cwac_pkg::REQ_NODE && $urandom_range(0, 1)) rq.req = REQ_BAD;
          rq.text_byte = 8'($urandom);
          rq.tree_sel = 3'($urandom);
          rq.node_index = 8'($urandom);
          rq.node_char = 8'($urandom);
          rq.node_offset = 4'($urandom);
          rq.node_left = 9'($urandom);
          rq.node_right = 9'($urandom);
          rq.node_label = 2'($urandom);
          // a stored node only names slots that hold a loaded node
          if (rq.req == cwac_pkg::REQ_NODE && rq.tree_sel <= 3'd4) begin
            rq.node_index = 8'($urandom_range(0, TREE_N - 1));
            rq.node_left = 9'(int'($urandom_range(0, TREE_N)) - 1);
            rq.node_right = 9'(int'($urandom_range(0, TREE_N)) - 1);
          end
        end
        put_item(rq);
      end
    end
    rq = '{default: '0};
    rq.req = cwac_pkg::REQ_FLUSH;
    put_item(rq);

    in_tvalid <= 1'b0;
    n = 0;
    while (accent_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (50) @(posedge clk);
    $display("run covered %0d input transfers and %0d result transfers", sent, received);
    $display("vowel labels seen plain/acute/umlaut/double acute: %0d/%0d/%0d/%0d",
             label_hits[0], label_hits[1], label_hits[2], label_hits[3]);
    if (errors == 0 && accent_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (accent_q.size() != 0) $error("%0d expected results never arrived", accent_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
design/cwac_pkg.sv
design/cwac_ctrl.sv
design/cwac_dp.sv
design/char_window_tree_accent_classifier_unit.sv
test/tb_char_window_tree_accent_classifier_unit.sv
